FILE: hdl/dadm_pkg.sv
// Shared types and codes for the dual-arm dispatch monitor.
`timescale 1ns / 1ps

package dadm_pkg;

	// Event codes carried by op
	typedef enum logic [1:0] {
		OP_BEGIN      = 2'd0,
		OP_LEFT_DONE  = 2'd1,
		OP_RIGHT_DONE = 2'd2,
		OP_FAIL       = 2'd3
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD       = 2'd1,
		ST_BUSY      = 2'd2,
		ST_TRANSPORT = 2'd3
	} status_t;

	// One input item
	typedef struct packed {
		op_t         op;
		logic [31:0] tick_ms;
		logic [31:0] tick_start_us;
		logic [31:0] left_launch_us;
		logic [31:0] right_launch_us;
	} item_t;

	// Full monitor state
	typedef struct packed {
		logic        active;
		logic        fault;
		logic        left_done;
		logic        right_done;
		logic [31:0] launches;
		logic [31:0] completions;
		logic [31:0] failures;
		logic [31:0] skew_peak;
		logic [31:0] late_peak;
		logic [31:0] saved_tick;
		logic [31:0] saved_left;
		logic [31:0] saved_right;
	} state_t;

	// Status plus the snapshot after the event
	typedef struct packed {
		status_t status;
		state_t  st;
	} result_t;

endpackage

FILE: hdl/dadm_in_if.sv
// Event channel: valid/ready handshake with the event payload.
`timescale 1ns / 1ps

interface dadm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] tick_ms;
	logic [31:0] tick_start_us;
	logic [31:0] left_launch_us;
	logic [31:0] right_launch_us;

	modport source (output valid, op, tick_ms, tick_start_us, left_launch_us,
		right_launch_us, input ready);
	modport sink (input valid, op, tick_ms, tick_start_us, left_launch_us,
		right_launch_us, output ready);
endinterface

FILE: hdl/dadm_out_if.sv
// Result channel: valid/ready handshake with status and state snapshot.
`timescale 1ns / 1ps

interface dadm_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  flags;
	logic        may_launch;
	logic [31:0] launches;
	logic [31:0] completions;
	logic [31:0] failures;
	logic [31:0] worst_skew_us;
	logic [31:0] worst_lateness_us;
	logic [31:0] recent_tick_ms;
	logic [31:0] recent_left_us;
	logic [31:0] recent_right_us;

	modport source (output valid, status, flags, may_launch, launches, completions,
		failures, worst_skew_us, worst_lateness_us, recent_tick_ms, recent_left_us,
		recent_right_us, input ready);
	modport sink (input valid, status, flags, may_launch, launches, completions,
		failures, worst_skew_us, worst_lateness_us, recent_tick_ms, recent_left_us,
		recent_right_us, output ready);
endinterface

FILE: hdl/dadm_core.sv
// Monitor state registers and the per-event update logic.
`timescale 1ns / 1ps

module dadm_core
	import dadm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output result_t res
);

	state_t      state_q;
	state_t      nxt;
	status_t     status;
	logic [31:0] skew;
	logic [31:0] late;
	logic        side_done;

	// Event decode and next state
	always_comb begin
		skew      = item.right_launch_us - item.left_launch_us;
		late      = item.left_launch_us - item.tick_start_us;
		side_done = (item.op == OP_LEFT_DONE) ? state_q.left_done : state_q.right_done;
		nxt       = state_q;
		status    = ST_OK;
		unique case (item.op) inside
			OP_BEGIN: begin
				if (state_q.fault) begin
					status = ST_TRANSPORT;
				end else if (state_q.active) begin
					status = ST_BUSY;
				end else if (skew[31]) begin
					status = ST_BAD;
				end else begin
					if (skew > state_q.skew_peak) nxt.skew_peak = skew;
					if (late > state_q.late_peak) nxt.late_peak = late;
					nxt.saved_tick  = item.tick_ms;
					nxt.saved_left  = item.left_launch_us;
					nxt.saved_right = item.right_launch_us;
					nxt.left_done   = 1'b0;
					nxt.right_done  = 1'b0;
					nxt.active      = 1'b1;
					nxt.launches    = state_q.launches + 32'd1;
				end
			end
			OP_LEFT_DONE, OP_RIGHT_DONE: begin
				if (!state_q.active || state_q.fault || side_done) begin
					status = ST_BAD;
				end else begin
					if (item.op == OP_LEFT_DONE) nxt.left_done = 1'b1;
					else nxt.right_done = 1'b1;
					// both sides done ends the launch
					if (nxt.left_done && nxt.right_done) begin
						nxt.active      = 1'b0;
						nxt.completions = state_q.completions + 32'd1;
					end
				end
			end
			OP_FAIL: begin
				if (!state_q.fault) nxt.failures = state_q.failures + 32'd1;
				nxt.fault  = 1'b1;
				nxt.active = 1'b0;
			end
			default: begin
				status = ST_OK;
			end
		endcase
		res.status = status;
		res.st     = nxt;
	end

	// State register, updated when an event leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (en) begin
			state_q <= nxt;
		end
	end

endmodule

FILE: hdl/dual_arm_dispatch_monitor.sv
// Top level of the dual-arm dispatch monitor.
// Usage:
//   req carries one event item (begin, left done, right done, fail) with the
//   tick and start times that begin uses. rsp returns exactly one item per
//   event: a status code and the full snapshot of the monitor after it.
//   Both channels use valid/ready; an item moves when both are high.
// Pipeline and throughput:
//   An event taken at one edge is registered in the input stage, evaluated
//   against the state registers by the update logic, and lands in the result
//   register once that register is free, and rsp.valid rises with it.
//   One event per cycle is sustained while rsp.ready stays high; the state
//   update is a combinational loop of flag checks, 32-bit subtracts and
//   compares.
// Reset:
//   arst_n clears all flags, counters, peaks and saved times to zero and
//   empties both stages.
// Backpressure:
//   When rsp.ready is low the result register holds; one more event can sit
//   in the input stage, after which req.ready drops. Nothing is lost.
`timescale 1ns / 1ps

module dual_arm_dispatch_monitor
	import dadm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	dadm_in_if.sink   req,
	dadm_out_if.source rsp
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res_nxt;
	logic    adv;

	// Handshake: input stage advances when the result register is free
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.op              <= op_t'(req.op);
			item_s1.tick_ms         <= req.tick_ms;
			item_s1.tick_start_us   <= req.tick_start_us;
			item_s1.left_launch_us  <= req.left_launch_us;
			item_s1.right_launch_us <= req.right_launch_us;
		end
	end

	dadm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.res    (res_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	// Output mapping
	assign rsp.valid             = valid_s2;
	assign rsp.status            = res_s2.status;
	assign rsp.flags             = {res_s2.st.right_done, res_s2.st.left_done,
		res_s2.st.fault, res_s2.st.active};
	assign rsp.may_launch        = !res_s2.st.active && !res_s2.st.fault;
	assign rsp.launches          = res_s2.st.launches;
	assign rsp.completions       = res_s2.st.completions;
	assign rsp.failures          = res_s2.st.failures;
	assign rsp.worst_skew_us     = res_s2.st.skew_peak;
	assign rsp.worst_lateness_us = res_s2.st.late_peak;
	assign rsp.recent_tick_ms    = res_s2.st.saved_tick;
	assign rsp.recent_left_us    = res_s2.st.saved_left;
	assign rsp.recent_right_us   = res_s2.st.saved_right;

	// A launch can never be active while the fault is latched
	a_no_active_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.flags[0] && rsp.flags[1]))
		else $error("active and faulted together");

	// A new result only appears after an event sat in the input stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(valid_s1))
		else $error("result without a pending event");

	// Input stage never backs up while the result side is free
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s2) |-> req.ready)
		else $error("input stalled with empty result register");

endmodule

FILE: tb/dual_arm_dispatch_monitor_tb.sv
// Self-checking testbench for the dual-arm dispatch monitor: launch event traffic vs. a predictor.
`timescale 1ns / 1ps

module dual_arm_dispatch_monitor_tb;
	import dadm_pkg::*;

	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_EVENTS    = 650;
	localparam int MAX_REPORTED    = 10;
	localparam int TAIL_CYCLES     = 4;

	logic clk = 1'b0;
	logic arst_n;

	dadm_in_if  req_if ();
	dadm_out_if rsp_if ();

	dual_arm_dispatch_monitor u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Predicted monitor state and the traffic in flight
	state_t      mon_state;
	item_t       pending_events[$];
	result_t     expected_reports[$];
	item_t       offered;
	result_t     want;
	int          send_gap_pct;
	int          recv_gap_pct;
	int          errors;
	int          reports_seen;
	int          hold_requests;
	int          hold_served;
	int          hold_left;
	int          quiet_cycles;
	int unsigned skew_spread;
	int unsigned late_spread;

	always #6 clk = ~clk;

	// Predict the status and snapshot that one event produces
	function automatic result_t track_event(item_t ev);
		logic [31:0] skew;
		logic [31:0] late;
		logic        side_done;
		result_t     r;
		skew = ev.right_launch_us - ev.left_launch_us;
		late = ev.left_launch_us - ev.tick_start_us;
		r.status = ST_OK;
		case (ev.op)
			OP_BEGIN: begin
				if (mon_state.fault)
					r.status = ST_TRANSPORT;
				else if (mon_state.active)
					r.status = ST_BUSY;
				else if (skew[31])
					r.status = ST_BAD;
				else begin
					if (skew > mon_state.skew_peak)
						mon_state.skew_peak = skew;
					if (late > mon_state.late_peak)
						mon_state.late_peak = late;
					mon_state.saved_tick  = ev.tick_ms;
					mon_state.saved_left  = ev.left_launch_us;
					mon_state.saved_right = ev.right_launch_us;
					mon_state.left_done   = 1'b0;
					mon_state.right_done  = 1'b0;
					mon_state.active      = 1'b1;
					mon_state.launches    = mon_state.launches + 32'd1;
				end
			end
			OP_LEFT_DONE, OP_RIGHT_DONE: begin
				side_done = (ev.op == OP_LEFT_DONE) ? mon_state.left_done : mon_state.right_done;
				if (!mon_state.active || mon_state.fault || side_done)
					r.status = ST_BAD;
				else begin
					if (ev.op == OP_LEFT_DONE)
						mon_state.left_done = 1'b1;
					else
						mon_state.right_done = 1'b1;
					// both arms finished: the launch is complete
					if (mon_state.left_done && mon_state.right_done) begin
						mon_state.active      = 1'b0;
						mon_state.completions = mon_state.completions + 32'd1;
					end
				end
			end
			default: begin
				// fault latches; only the first one is counted
				if (!mon_state.fault)
					mon_state.failures = mon_state.failures + 32'd1;
				mon_state.fault  = 1'b1;
				mon_state.active = 1'b0;
			end
		endcase
		r.st = mon_state;
		return r;
	endfunction

	// Event with random time fields (ignored unless op is begin)
	function automatic item_t make_event(op_t op);
		item_t e;
		e.op              = op;
		e.tick_ms         = $urandom;
		e.tick_start_us   = $urandom;
		e.left_launch_us  = $urandom;
		e.right_launch_us = $urandom;
		return e;
	endfunction

	function automatic item_t make_begin(logic [31:0] tick, logic [31:0] tstart,
			logic [31:0] left, logic [31:0] right);
		item_t e;
		e.op              = OP_BEGIN;
		e.tick_ms         = tick;
		e.tick_start_us   = tstart;
		e.left_launch_us  = left;
		e.right_launch_us = right;
		return e;
	endfunction

	// Begin whose right arm starts ahead of the left (sign bit of skew set)
	function automatic item_t make_skewed_begin();
		item_t e;
		e = make_event(OP_BEGIN);
		e.right_launch_us = e.left_launch_us + ($urandom | 32'h8000_0000);
		return e;
	endfunction

	// One launch: begin, both completions in random order, with occasional
	// stray begins and repeated completions mixed in
	task automatic queue_launch();
		logic [31:0] left;
		logic        left_first;
		op_t         first_op;
		op_t         second_op;
		skew_spread += 150000;
		late_spread += 150000;
		left = $urandom;
		if ($urandom_range(0, 9) == 0)
			pending_events.push_back(make_skewed_begin());
		else
			pending_events.push_back(make_begin($urandom, left - $urandom_range(0, late_spread),
				left, left + $urandom_range(0, skew_spread)));
		if ($urandom_range(0, 6) == 0)
			pending_events.push_back(make_skewed_begin());
		left_first = $urandom_range(0, 1);
		first_op   = left_first ? OP_LEFT_DONE : OP_RIGHT_DONE;
		second_op  = left_first ? OP_RIGHT_DONE : OP_LEFT_DONE;
		pending_events.push_back(make_event(first_op));
		if ($urandom_range(0, 6) == 0)
			pending_events.push_back(make_event(first_op));
		pending_events.push_back(make_event(second_op));
	endtask

	// Mostly well-formed launches, some stray events
	task automatic queue_traffic(int count);
		int goal;
		op_t op;
		goal = pending_events.size() + count;
		while (pending_events.size() < goal) begin
			if ($urandom_range(0, 99) < 85)
				queue_launch();
			else begin
				op = op_t'($urandom_range(0, 2));
				if (op == OP_BEGIN)
					pending_events.push_back(make_skewed_begin());
				else
					pending_events.push_back(make_event(op));
			end
		end
	endtask

	task automatic queue_directed();
		// completions with nothing launched
		pending_events.push_back(make_event(OP_LEFT_DONE));
		pending_events.push_back(make_event(OP_RIGHT_DONE));
		// right before left, and skew exactly at the sign bit
		pending_events.push_back(make_begin(32'd1, 32'd0, 32'd100, 32'd99));
		pending_events.push_back(make_begin(32'd2, 32'd0, 32'd0, 32'h8000_0000));
		// all-zero launch, then begin while busy
		pending_events.push_back(make_begin(32'd0, 32'd0, 32'd0, 32'd0));
		pending_events.push_back(make_begin(32'd7, 32'd10, 32'd20, 32'd30));
		pending_events.push_back(make_event(OP_LEFT_DONE));
		pending_events.push_back(make_event(OP_LEFT_DONE));
		pending_events.push_back(make_event(OP_RIGHT_DONE));
		pending_events.push_back(make_event(OP_RIGHT_DONE));
		// start times that wrap past zero
		pending_events.push_back(make_begin(32'd3, 32'hFFFF_FF00, 32'hFFFF_FFF0, 32'h0000_0010));
		pending_events.push_back(make_event(OP_RIGHT_DONE));
		pending_events.push_back(make_event(OP_RIGHT_DONE));
		pending_events.push_back(make_event(OP_LEFT_DONE));
		// equal start times
		pending_events.push_back(make_begin(32'd4, 32'd100, 32'd100, 32'd100));
		pending_events.push_back(make_event(OP_RIGHT_DONE));
		pending_events.push_back(make_event(OP_LEFT_DONE));
	endtask

	// Peak extremes, then the fault and what follows it
	task automatic queue_extremes_and_fault();
		pending_events.push_back(make_begin(32'hFFFF_FFFF, 32'd1, 32'd0, 32'h7FFF_FFFF));
		pending_events.push_back(make_event(OP_LEFT_DONE));
		pending_events.push_back(make_event(OP_RIGHT_DONE));
		pending_events.push_back(make_begin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		pending_events.push_back(make_event(OP_LEFT_DONE));
		// fault during an active launch keeps the done flags
		pending_events.push_back(make_event(OP_FAIL));
		pending_events.push_back(make_begin($urandom, 32'd0, 32'd5, 32'd6));
		pending_events.push_back(make_event(OP_RIGHT_DONE));
		pending_events.push_back(make_event(OP_LEFT_DONE));
		pending_events.push_back(make_event(OP_FAIL));
		repeat (20)
			pending_events.push_back(make_event(op_t'($urandom_range(0, 3))));
	endtask

	task automatic note_error(string msg);
		errors++;
		if (errors <= MAX_REPORTED)
			$display("%s", msg);
	endtask

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (act_val !== exp_val)
			note_error($sformatf("report %0d %s: expected %h, actual %h",
				reports_seen, name, exp_val, act_val));
	endtask

	task automatic drain_events();
		while (pending_events.size() != 0 || req_if.valid)
			@(negedge clk);
	endtask

	// Event driver: holds an item until taken, predicts it on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready)
				expected_reports.push_back(track_event(offered));
			if (!req_if.valid || req_if.ready) begin
				if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					offered = pending_events.pop_front();
					req_if.valid           <= 1'b1;
					req_if.op              <= offered.op;
					req_if.tick_ms         <= offered.tick_ms;
					req_if.tick_start_us   <= offered.tick_start_us;
					req_if.left_launch_us  <= offered.left_launch_us;
					req_if.right_launch_us <= offered.right_launch_us;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Report monitor: checks each item, drives ready with random and long stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				reports_seen++;
				if (expected_reports.size() == 0) begin
					note_error($sformatf("report %0d arrived with none expected", reports_seen));
				end else begin
					want = expected_reports.pop_front();
					check_field("status", 32'(want.status), 32'(rsp_if.status));
					check_field("flags", 32'({want.st.right_done, want.st.left_done,
						want.st.fault, want.st.active}), 32'(rsp_if.flags));
					check_field("may_launch", 32'(!want.st.active && !want.st.fault),
						32'(rsp_if.may_launch));
					check_field("launches", want.st.launches, rsp_if.launches);
					check_field("completions", want.st.completions, rsp_if.completions);
					check_field("failures", want.st.failures, rsp_if.failures);
					check_field("worst_skew_us", want.st.skew_peak, rsp_if.worst_skew_us);
					check_field("worst_lateness_us", want.st.late_peak,
						rsp_if.worst_lateness_us);
					check_field("recent_tick_ms", want.st.saved_tick, rsp_if.recent_tick_ms);
					check_field("recent_left_us", want.st.saved_left, rsp_if.recent_left_us);
					check_field("recent_right_us", want.st.saved_right, rsp_if.recent_right_us);
				end
			end
			if (hold_requests != hold_served) begin
				hold_served++;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
			end
		end
	end

	// Watchdog on cycles where neither channel moves an item
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n                 = 1'b0;
		req_if.valid           = 1'b0;
		req_if.op              = OP_BEGIN;
		req_if.tick_ms         = '0;
		req_if.tick_start_us   = '0;
		req_if.left_launch_us  = '0;
		req_if.right_launch_us = '0;
		rsp_if.ready           = 1'b0;
		mon_state              = '0;
		errors                 = 0;
		reports_seen           = 0;
		hold_requests          = 0;
		hold_served            = 0;
		hold_left              = 0;
		quiet_cycles           = 0;
		skew_spread            = 1000;
		late_spread            = 1000;

		// sender rarely idles, receiver mostly stalls
		send_gap_pct = 10;
		recv_gap_pct = 64;
		queue_directed();
		queue_traffic(PHASE_EVENTS);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		drain_events();

		// sender mostly idles, receiver rarely stalls
		send_gap_pct = 64;
		recv_gap_pct = 10;
		queue_traffic(PHASE_EVENTS);
		drain_events();

		// full rate, opened by one long receiver hold-off to back the block up
		send_gap_pct = 0;
		recv_gap_pct = 0;
		hold_requests++;
		queue_traffic(PHASE_EVENTS);
		queue_extremes_and_fault();
		drain_events();

		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0 && expected_reports.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
